>>> src/pfba_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types for the page frame bitmap allocator
package pfba_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = $clog2(WORD_COUNT);
    localparam int WCNT_W     = ADDR_W + 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int FRAME_W    = 12;
    localparam int CNT_W      = 13;

    localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_RD,
        ST_FREE_WR
    } t_state;

    // result of the lowest-clear-bit search on one bitmap word
    typedef struct packed {
        logic             full;
        logic [BIT_W-1:0] idx;
    } t_find;

endpackage

>>> src/pfba_bitmap_ram.sv
`timescale 1ns / 1ps
// usage bitmap store: one write port, one registered read port, per-word valid bits
module pfba_bitmap_ram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [pfba_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [pfba_pkg::WORD_BITS-1:0] o_rd_data,
    input  logic                          i_wr_en,
    input  logic [pfba_pkg::ADDR_W-1:0]   i_wr_addr,
    input  logic [pfba_pkg::WORD_BITS-1:0] i_wr_data
);
    import pfba_pkg::*;

    logic [WORD_BITS-1:0]  r_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] r_word_vld;
    logic [WORD_BITS-1:0]  r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_word_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_word_vld[i_rd_addr];
            end
        end
    end

    // a word never written since reset reads as all free
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

>>> src/pfba_zero_find.sv
`timescale 1ns / 1ps
// lowest clear bit search over one bitmap word
module pfba_zero_find (
    input  logic [pfba_pkg::WORD_BITS-1:0] i_word,
    output pfba_pkg::t_find                o_find
);
    import pfba_pkg::*;

    always_comb begin
        o_find.full = (i_word == FULL_WORD);
        o_find.idx  = '0;
        // walk from the top so the lowest clear bit wins
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!i_word[b]) begin
                o_find.idx = BIT_W'(b);
            end
        end
    end

endmodule

>>> src/page_frame_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// Page frame bitmap allocator, first fit over 32-frame words.
// An alloc scans one word a cycle, first fit, over the frame_count/32 whole words;
// with no whole word to scan it reports full.
// One item at a time: the next transaction is taken once the result has left or is leaving.
// Synchronous active-low reset: every frame free at once (per-word valid bits), frame_count 4096.
module page_frame_bitmap_allocator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_kind,
    input  logic [pfba_pkg::FRAME_W-1:0] i_current_frame,
    input  logic                         i_is_kernel,
    input  logic                         i_is_writeable,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [pfba_pkg::FRAME_W-1:0] o_new_frame,
    output logic                         o_present,
    output logic                         o_writable,
    output logic                         o_user_mode,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pfba_pkg::CNT_W-1:0]   i_cfg_frame_count
);
    import pfba_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_frame_count;
    logic [WCNT_W-1:0]    r_rd, n_rd;
    logic [ADDR_W-1:0]    r_ck, n_ck;
    logic                 r_ck_v, n_ck_v;
    logic [FRAME_W-1:0]   r_cur, n_cur;
    logic                 r_wr, n_wr;
    logic                 r_kern, n_kern;

    logic                 r_o_valid;
    logic [1:0]           r_o_status, n_o_status;
    logic [FRAME_W-1:0]   r_o_frame, n_o_frame;
    logic                 r_o_pres, n_o_pres;
    logic                 r_o_wr, n_o_wr;
    logic                 r_o_user, n_o_user;
    logic                 res_load;

    logic                 in_acc;
    logic                 in_rdy;
    logic [WCNT_W-1:0]    words;
    logic                 scan_found;
    logic                 scan_full;

    logic                 ram_rd_en;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;
    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    t_find                find;

    pfba_bitmap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data)
    );

    pfba_zero_find u_find (
        .i_word (ram_rd_data),
        .o_find (find)
    );

    assign words = (r_frame_count > CNT_W'(MAX_FRAMES)) ? WCNT_W'(WORD_COUNT)
                                                         : WCNT_W'(r_frame_count >> BIT_W);

    assign in_rdy = (r_state == ST_IDLE) && (!r_o_valid || i_ready);
    assign in_acc = i_valid && in_rdy;

    assign scan_found = r_ck_v && !find.full;
    assign scan_full  = !r_ck_v && (r_rd >= words);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_kind == KIND_ALLOC && i_current_frame == '0) begin
                        n_state = ST_SCAN;
                    end else if (i_kind == KIND_FREE && i_current_frame != '0) begin
                        n_state = ST_FREE_RD;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_found || scan_full) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FREE_RD: n_state = ST_FREE_WR;
            ST_FREE_WR: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_rd        = r_rd;
        n_ck        = r_ck;
        n_ck_v      = r_ck_v;
        n_cur       = r_cur;
        n_wr        = r_wr;
        n_kern      = r_kern;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_rd[ADDR_W-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_ck;
        ram_wr_data = ram_rd_data;
        res_load    = 1'b0;
        n_o_status  = STATUS_DONE;
        n_o_frame   = '0;
        n_o_pres    = 1'b0;
        n_o_wr      = 1'b0;
        n_o_user    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cur  = i_current_frame;
                    n_wr   = i_is_writeable;
                    n_kern = i_is_kernel;
                    n_rd   = '0;
                    n_ck_v = 1'b0;
                    // mapped entry on alloc, or nothing to free
                    if ((i_kind == KIND_ALLOC) == (i_current_frame != '0)) begin
                        res_load   = 1'b1;
                        n_o_status = STATUS_IGNORED;
                        n_o_frame  = i_current_frame;
                    end
                end
            end
            ST_SCAN: begin
                // read word r_rd while checking the word read last cycle
                ram_rd_en = (r_rd < words) && !scan_found;
                n_rd      = r_rd + 1'b1;
                n_ck      = r_rd[ADDR_W-1:0];
                n_ck_v    = r_rd < words;
                if (scan_found) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_ck;
                    ram_wr_data = ram_rd_data | (WORD_BITS'(1) << find.idx);
                    res_load    = 1'b1;
                    n_o_status  = STATUS_DONE;
                    n_o_frame   = {r_ck, find.idx};
                    n_o_pres    = 1'b1;
                    n_o_wr      = r_wr;
                    n_o_user    = !r_kern;
                end else if (scan_full) begin
                    res_load   = 1'b1;
                    n_o_status = STATUS_FULL;
                end
            end
            ST_FREE_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_cur[FRAME_W-1:BIT_W];
            end
            ST_FREE_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_cur[FRAME_W-1:BIT_W];
                ram_wr_data = ram_rd_data & ~(WORD_BITS'(1) << r_cur[BIT_W-1:0]);
                res_load    = 1'b1;
                n_o_status  = STATUS_DONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_frame_count <= CNT_W'(MAX_FRAMES);
            r_o_valid     <= 1'b0;
            r_ck_v        <= 1'b0;
            r_rd          <= '0;
        end else begin
            r_state <= n_state;
            r_ck_v  <= n_ck_v;
            r_rd    <= n_rd;
            if (i_cfg_valid) begin
                r_frame_count <= i_cfg_frame_count;
            end
            if (res_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ck   <= n_ck;
        r_cur  <= n_cur;
        r_wr   <= n_wr;
        r_kern <= n_kern;
        if (res_load) begin
            r_o_status <= n_o_status;
            r_o_frame  <= n_o_frame;
            r_o_pres   <= n_o_pres;
            r_o_wr     <= n_o_wr;
            r_o_user   <= n_o_user;
        end
    end

    assign o_ready     = in_rdy;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_new_frame = r_o_frame;
    assign o_present   = r_o_pres;
    assign o_writable  = r_o_wr;
    assign o_user_mode = r_o_user;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the page frame bitmap allocator: random and directed traffic
module tb;
    import pfba_pkg::*;

    typedef struct packed {
        logic               kind;
        logic [FRAME_W-1:0] frame;
        logic               kernel;
        logic               writeable;
    } t_page_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame;
        logic               present;
        logic               writable;
        logic               user;
    } t_page_entry;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_kind = KIND_ALLOC;
    logic [FRAME_W-1:0] i_current_frame = '0;
    logic               i_is_kernel = 1'b0;
    logic               i_is_writeable = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic [FRAME_W-1:0] o_new_frame;
    logic               o_present;
    logic               o_writable;
    logic               o_user_mode;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CNT_W-1:0]   i_cfg_frame_count = '0;

    // shadow of the frame usage bitmap and the frame count register
    logic [WORD_BITS-1:0] used_map [WORD_COUNT];
    logic [CNT_W-1:0]     model_frame_count;

    t_page_req   pending_reqs[$];
    t_page_entry expected_entries[$];
    t_page_req   next_req;
    t_page_entry seen_entry;
    t_page_entry want_entry;

    int  reqs_issued = 0;
    int  reqs_accepted = 0;
    int  errors = 0;
    int  send_idle_pct = 10;
    int  recv_idle_pct = 60;
    int  hold_left = 0;
    bit  hold_request = 1'b0;
    bit  hold_fired = 1'b0;
    logic req_taken = 1'b0;

    page_frame_bitmap_allocator_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_kind            (i_kind),
        .i_current_frame   (i_current_frame),
        .i_is_kernel       (i_is_kernel),
        .i_is_writeable    (i_is_writeable),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_new_frame       (o_new_frame),
        .o_present         (o_present),
        .o_writable        (o_writable),
        .o_user_mode       (o_user_mode),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_frame_count (i_cfg_frame_count)
    );

    always #6 i_clk = ~i_clk;

    // first-fit allocation / release against the shadow bitmap
    function automatic t_page_entry map_request(t_page_req req);
        t_page_entry res;
        int          span;
        int          words;
        bit          found;
        res = '0;
        if (req.kind == KIND_ALLOC) begin
            if (req.frame != 0) begin
                res.status = STATUS_IGNORED;
                res.frame  = req.frame;
            end else begin
                span  = (model_frame_count > MAX_FRAMES) ? MAX_FRAMES : model_frame_count;
                words = span / WORD_BITS;
                found = 1'b0;
                for (int w = 0; w < words && !found; w++) begin
                    if (used_map[w] != FULL_WORD) begin
                        for (int b = 0; b < WORD_BITS && !found; b++) begin
                            if (!used_map[w][b]) begin
                                found          = 1'b1;
                                used_map[w][b] = 1'b1;
                                res.frame      = FRAME_W'(w * WORD_BITS + b);
                            end
                        end
                    end
                end
                if (found) begin
                    res.status   = STATUS_DONE;
                    res.present  = 1'b1;
                    res.writable = req.writeable;
                    res.user     = ~req.kernel;
                end else begin
                    res.status = STATUS_FULL;
                end
            end
        end else if (req.frame == 0) begin
            res.status = STATUS_IGNORED;
        end else begin
            used_map[req.frame / WORD_BITS][req.frame % WORD_BITS] = 1'b0;
            res.status = STATUS_DONE;
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input t_page_entry want,
                                 input t_page_entry got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: exp status=%0d frame=%0d p=%b w=%b u=%b,",
                     $realtime, what, want.status, want.frame, want.present, want.writable,
                     want.user, " got status=%0d frame=%0d p=%b w=%b u=%b",
                     got.status, got.frame, got.present, got.writable, got.user);
    endtask

    task automatic queue_req(input logic kind, input int frame, input logic kernel,
                             input logic writeable);
        pending_reqs.push_back('{kind, FRAME_W'(frame), kernel, writeable});
        reqs_issued++;
    endtask

    // wait until every transaction has been accepted and answered
    task automatic drain();
        do @(negedge i_clk);
        while (reqs_accepted != reqs_issued || expected_entries.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_frame_count(input int count);
        @(negedge i_clk);
        i_cfg_frame_count <= CNT_W'(count);
        i_cfg_valid       <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        model_frame_count = CNT_W'(count);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req        = pending_reqs.pop_front();
                i_valid         <= 1'b1;
                i_kind          <= next_req.kind;
                i_current_frame <= next_req.frame;
                i_is_kernel     <= next_req.kernel;
                i_is_writeable  <= next_req.writeable;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // long back-pressure stretch, counted here
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end else if (hold_request && !hold_fired) begin
            hold_left  <= 400;
            hold_fired <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check results, then predict the transaction accepted at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                seen_entry = '{o_status, o_new_frame, o_present, o_writable, o_user_mode};
                if (expected_entries.size() == 0) begin
                    note_mismatch("result with nothing outstanding", '0, seen_entry);
                end else begin
                    want_entry = expected_entries.pop_front();
                    if (seen_entry.status !== want_entry.status
                            || seen_entry.frame !== want_entry.frame
                            || seen_entry.present !== want_entry.present
                            || seen_entry.writable !== want_entry.writable
                            || seen_entry.user !== want_entry.user)
                        note_mismatch("result mismatch", want_entry, seen_entry);
                end
            end
            if (i_valid && o_ready) begin
                expected_entries.push_back(
                    map_request('{i_kind, i_current_frame, i_is_kernel, i_is_writeable}));
                reqs_accepted++;
            end
        end
    end

    initial begin
        #5ms;
        $display("page_frame_bitmap_allocator_top regression: fail");
        $finish;
    end

    initial begin
        int phase_frames [7];
        int phase_items [7];
        int span;
        int hi;
        int pick;
        phase_frames = '{32, 64, 160, 4096, 31, 8191, 96};
        phase_items  = '{100, 100, 100, 100, 40, 100, 140};
        foreach (used_map[w])
            used_map[w] = '0;
        model_frame_count = CNT_W'(MAX_FRAMES);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: frame 0 handed out first, then mapped entries, frees and reuse
        queue_req(KIND_ALLOC, 0, 1'b0, 1'b0);
        queue_req(KIND_ALLOC, 0, 1'b1, 1'b1);
        queue_req(KIND_ALLOC, 0, 1'b0, 1'b1);
        queue_req(KIND_ALLOC, 0, 1'b1, 1'b0);
        queue_req(KIND_ALLOC, 4095, 1'b1, 1'b1);
        queue_req(KIND_ALLOC, 12'h555, 1'b0, 1'b1);
        queue_req(KIND_FREE, 0, 1'b1, 1'b1);
        queue_req(KIND_FREE, 1, 1'b0, 1'b0);
        queue_req(KIND_ALLOC, 0, 1'b0, 1'b1);
        queue_req(KIND_FREE, 4095, 1'b0, 1'b0);
        queue_req(KIND_FREE, 2, 1'b1, 1'b0);
        queue_req(KIND_FREE, 2, 1'b0, 1'b1);
        queue_req(KIND_ALLOC, 0, 1'b1, 1'b1);
        queue_req(KIND_FREE, 12'hAAA, 1'b1, 1'b1);
        drain();
        // no whole word scanned: alloc reports full
        write_frame_count(0);
        queue_req(KIND_ALLOC, 0, 1'b0, 1'b1);
        queue_req(KIND_FREE, 3, 1'b0, 1'b0);
        queue_req(KIND_ALLOC, 0, 1'b1, 1'b0);
        drain();
        write_frame_count(31);
        queue_req(KIND_ALLOC, 0, 1'b0, 1'b0);
        drain();
        // count above the storage saturates
        write_frame_count(8191);
        queue_req(KIND_ALLOC, 0, 1'b1, 1'b1);
        drain();

        for (int p = 0; p < 7; p++) begin
            if (p < 2) begin
                send_idle_pct = 10;
                recv_idle_pct = 60;
            end else if (p < 5) begin
                send_idle_pct = 60;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_frame_count(phase_frames[p]);
            span = (phase_frames[p] > MAX_FRAMES) ? MAX_FRAMES : phase_frames[p];
            // frees aim mostly at the low frames where allocations land
            hi = (span < 64) ? 63 : ((span > 512) ? 255 : span - 1);
            for (int n = 0; n < phase_items[p]; n++) begin
                pick = $urandom_range(99);
                if (pick < 55)
                    queue_req(KIND_ALLOC, 0, $urandom_range(1), $urandom_range(1));
                else if (pick < 85)
                    queue_req(KIND_FREE, $urandom_range(hi, 1), $urandom_range(1),
                              $urandom_range(1));
                else if (pick < 93)
                    queue_req(KIND_ALLOC, $urandom_range(4095, 1), $urandom_range(1),
                              $urandom_range(1));
                else if (pick < 98)
                    queue_req(KIND_FREE, $urandom_range(4095), $urandom_range(1),
                              $urandom_range(1));
                else
                    queue_req(KIND_FREE, 0, $urandom_range(1), $urandom_range(1));
            end
            if (p == 6)
                hold_request = 1'b1;
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (errors == 0)
            $display("page_frame_bitmap_allocator_top regression: pass");
        else
            $display("page_frame_bitmap_allocator_top regression: fail");
        $finish;
    end

endmodule

>>> files.f
src/pfba_pkg.sv
src/pfba_bitmap_ram.sv
src/pfba_zero_find.sv
src/page_frame_bitmap_allocator_top.sv
sim/tb.sv
